// ===== src/mcss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcss_pkg;

    localparam int PAW = 4;
    localparam int PDW = 32;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;
    localparam logic [1:0] REG_SPACING  = 2'd3;

    localparam logic [15:0] SPACING_RST = 16'd256;

    localparam logic [2:0] KIND_CORNER = 3'd0;
    localparam logic [2:0] KIND_MAX    = 3'd5;

    // quotient bits of the step division; the quotient never exceeds the spacing
    localparam int QW = 17;

    typedef struct packed {
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic [22:0]        radius;
        logic [15:0]        spacing;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/map_crop_segment_sampler.sv =====
// Map crop and segment sampler.
// Input channel (i_valid / o_stall) takes one map element per item: a corner
// (kind 0) or a marking segment (kinds 1..5); kinds 6 and 7 are dropped.
// Output channel (o_valid / i_stall) gives one item per sample point, with
// o_last on the final point of an element and o_truncated on every point of
// an element whose count was capped at MAX_POINTS.
// Work runs on one shared multiplier and one shared compare-subtract unit.
// Per element: the multiply steps, then a check; a corner then emits its
// point if it lies inside the circle. A kept segment adds the square-root
// steps, a length step and two divisions (x, then y), then one point per
// cycle while the receiver takes them.
// o_stall is high from acceptance until the final point is loaded into the
// output register or the element is dropped. A stalled result holds in that register; emission waits.
// Reset clears the sequencer and output valid and loads register defaults
// (spacing 256, all others zero). Configure over APB only while idle.
`timescale 1ns / 1ps
`default_nettype none

module map_crop_segment_sampler
    import mcss_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [PAW-1:0]               paddr,
    input  wire logic [PDW-1:0]               pwdata,
    output logic [PDW-1:0]                    prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [2:0]                   i_kind,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [COORD_BITS-1:0]      o_point_x,
    output logic signed [COORD_BITS-1:0]      o_point_y,
    output logic [2:0]                        o_layer,
    output logic                              o_last,
    output logic                              o_truncated
);

    localparam int C     = COORD_BITS;
    localparam int CW    = (C > 24) ? C : 24;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = 2 * DW + 2;
    localparam int RW    = DW + 1;
    localparam int CNTW  = $clog2(RW) + 1;
    localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NSTEP = 10;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;
    localparam logic [2:0] S_DIVX = 3'd5;
    localparam logic [2:0] S_DIVY = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    localparam logic [3:0] M_RR  = 4'd0;
    localparam logic [3:0] M_AX0 = 4'd1;
    localparam logic [3:0] M_AY0 = 4'd2;
    localparam logic [3:0] M_AX1 = 4'd3;
    localparam logic [3:0] M_AY1 = 4'd4;
    localparam logic [3:0] M_DX2 = 4'd5;
    localparam logic [3:0] M_DY2 = 4'd6;
    localparam logic [3:0] M_SX  = 4'd7;
    localparam logic [3:0] M_SY  = 4'd8;
    localparam logic [3:0] M_LIM = 4'd9;

    t_cfg w_cfg;

    mcss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic [2:0]              r_state;
    logic [3:0]              r_step;
    logic [CNTW-1:0]         r_cnt;
    logic                    r_ovalid;

    logic [2:0]              r_kind;
    logic signed [C-1:0]     r_sx, r_sy, r_ex, r_ey;
    logic [PW-1:0]           r_prod [NSTEP];
    logic [SW-1:0]           r_acc, r_root, r_one, r_den;
    logic [QW-1:0]           r_quo, r_ax, r_ay;
    logic [RW-1:0]           r_len;
    logic [RW:0]             r_bx, r_by;
    logic [RW+1:0]           r_rx, r_ry, r_accs;
    logic [C-1:0]            r_qx, r_qy;
    logic [IW-1:0]           r_i;
    logic                    r_corner, r_trunc;
    logic signed [C-1:0]     r_ox, r_oy;
    logic [2:0]              r_olayer;
    logic                    r_olast, r_otrunc;

    logic                    w_in_acc, w_adv, w_last;
    logic [15:0]             w_s;
    logic signed [DW-1:0]    w_cx, w_cy, w_sxe, w_sye, w_exe, w_eye;
    logic signed [DW-1:0]    w_dx0, w_dy0, w_dx1, w_dy1, w_dx, w_dy;
    logic [DW-1:0]           w_ax0, w_ay0, w_ax1, w_ay1, w_mdx, w_mdy, w_rad;
    logic [DW-1:0]           w_ma, w_mb;
    logic [PW-1:0]           w_prod;
    logic                    w_in0, w_in1;
    logic [SW-1:0]           w_cand, w_diff;
    logic                    w_ge;
    logic [QW-1:0]           w_quo_n;
    logic [SW-1:0]           w_rem_n;
    logic [RW+1:0]           w_twolen, w_sumx, w_sumy, w_accs_n;
    logic                    w_wrapx, w_wrapy;
    logic [C-1:0]            w_offx, w_offy;

    assign w_in_acc = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign w_s      = (w_cfg.spacing == 16'd0) ? 16'd1 : w_cfg.spacing;

    assign w_cx  = {{(DW-24){w_cfg.center_x[23]}}, w_cfg.center_x};
    assign w_cy  = {{(DW-24){w_cfg.center_y[23]}}, w_cfg.center_y};
    assign w_sxe = {{(DW-C){r_sx[C-1]}}, r_sx};
    assign w_sye = {{(DW-C){r_sy[C-1]}}, r_sy};
    assign w_exe = {{(DW-C){r_ex[C-1]}}, r_ex};
    assign w_eye = {{(DW-C){r_ey[C-1]}}, r_ey};
    assign w_dx0 = w_sxe - w_cx;
    assign w_dy0 = w_sye - w_cy;
    assign w_dx1 = w_exe - w_cx;
    assign w_dy1 = w_eye - w_cy;
    assign w_dx  = w_exe - w_sxe;
    assign w_dy  = w_eye - w_sye;
    assign w_ax0 = w_dx0[DW-1] ? DW'(-w_dx0) : DW'(w_dx0);
    assign w_ay0 = w_dy0[DW-1] ? DW'(-w_dy0) : DW'(w_dy0);
    assign w_ax1 = w_dx1[DW-1] ? DW'(-w_dx1) : DW'(w_dx1);
    assign w_ay1 = w_dy1[DW-1] ? DW'(-w_dy1) : DW'(w_dy1);
    assign w_mdx = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    assign w_mdy = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
    assign w_rad = {{(DW-23){1'b0}}, w_cfg.radius};

    // shared multiplier
    always_comb begin
        unique case (r_step)
            M_RR:    begin w_ma = w_rad; w_mb = w_rad; end
            M_AX0:   begin w_ma = w_ax0; w_mb = w_ax0; end
            M_AY0:   begin w_ma = w_ay0; w_mb = w_ay0; end
            M_AX1:   begin w_ma = w_ax1; w_mb = w_ax1; end
            M_AY1:   begin w_ma = w_ay1; w_mb = w_ay1; end
            M_DX2:   begin w_ma = w_mdx; w_mb = w_mdx; end
            M_DY2:   begin w_ma = w_mdy; w_mb = w_mdy; end
            M_SX:    begin w_ma = {{(DW-16){1'b0}}, w_s}; w_mb = w_mdx; end
            M_SY:    begin w_ma = {{(DW-16){1'b0}}, w_s}; w_mb = w_mdy; end
            M_LIM:   begin w_ma = {{(DW-16){1'b0}}, w_s}; w_mb = DW'(MAX_POINTS + 1); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_in0 = (w_ax0 <= w_rad) && (w_ay0 <= w_rad) &&
                   (({1'b0, r_prod[M_AX0]} + {1'b0, r_prod[M_AY0]}) < {1'b0, r_prod[M_RR]});
    assign w_in1 = (w_ax1 <= w_rad) && (w_ay1 <= w_rad) &&
                   (({1'b0, r_prod[M_AX1]} + {1'b0, r_prod[M_AY1]}) < {1'b0, r_prod[M_RR]});

    // shared compare-subtract: root digits and quotient bits
    assign w_cand  = (r_state == S_SQRT) ? (r_root + r_one) : r_den;
    assign w_ge    = (r_acc >= w_cand);
    assign w_diff  = r_acc - w_cand;
    assign w_quo_n = {r_quo[QW-2:0], w_ge};
    assign w_rem_n = w_ge ? w_diff : r_acc;

    assign w_twolen = {1'b0, r_len, 1'b0};
    assign w_sumx   = r_rx + {1'b0, r_bx};
    assign w_sumy   = r_ry + {1'b0, r_by};
    assign w_wrapx  = (w_sumx >= w_twolen);
    assign w_wrapy  = (w_sumy >= w_twolen);
    assign w_accs_n = r_accs + (RW+2)'(w_s);
    assign w_offx   = w_dx[DW-1] ? -r_qx : r_qx;
    assign w_offy   = w_dy[DW-1] ? -r_qy : r_qy;

    assign w_adv  = (r_state == S_EMIT) && (!r_ovalid || !i_stall);
    assign w_last = r_corner || (w_accs_n > {2'b00, r_len}) ||
                    (r_i == IW'(MAX_POINTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (!r_ovalid || !i_stall) begin
                r_ovalid <= (r_state == S_EMIT);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_kind <= KIND_MAX) begin
                        r_state <= S_MUL;
                        r_step  <= '0;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'(NSTEP - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_kind == KIND_CORNER) begin
                        r_state <= w_in0 ? S_EMIT : S_IDLE;
                    end else begin
                        r_state <= (w_in0 || w_in1) ? S_SQRT : S_IDLE;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == CNTW'(RW - 1)) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_state <= (r_root >= SW'(w_s)) ? S_DIVX : S_IDLE;
                end
                S_DIVX: begin
                    if (r_cnt == CNTW'(QW - 1)) begin
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (r_cnt == CNTW'(QW - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_adv && w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_kind <= i_kind;
                    r_sx   <= i_start_x;
                    r_sy   <= i_start_y;
                    r_ex   <= i_end_x;
                    r_ey   <= i_end_y;
                end
            end
            S_MUL: begin
                r_prod[r_step] <= w_prod;
            end
            S_CHK: begin
                r_acc    <= {{(SW-PW-1){1'b0}}, ({1'b0, r_prod[M_DX2]} + {1'b0, r_prod[M_DY2]})};
                r_root   <= '0;
                r_one    <= SW'(1) << (SW - 2);
                r_cnt    <= '0;
                r_qx     <= '0;
                r_qy     <= '0;
                r_i      <= '0;
                r_corner <= (r_kind == KIND_CORNER);
                r_trunc  <= 1'b0;
            end
            S_SQRT: begin
                if (w_ge) begin
                    r_acc  <= w_diff;
                    r_root <= (r_root >> 1) + r_one;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_one <= r_one >> 2;
                r_cnt <= r_cnt + CNTW'(1);
            end
            S_LEN: begin
                r_len <= r_root[RW-1:0];
                r_acc <= {{(SW-PW-1){1'b0}}, r_prod[M_SX], 1'b0};
                r_den <= SW'({r_root[RW-1:0], 1'b0}) << (QW - 1);
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_DIVX, S_DIVY: begin
                if (r_cnt == CNTW'(QW - 1)) begin
                    r_cnt <= '0;
                    r_quo <= '0;
                    if (r_state == S_DIVX) begin
                        r_ax  <= w_quo_n;
                        r_bx  <= w_rem_n[RW:0];
                        r_acc <= {{(SW-PW-1){1'b0}}, r_prod[M_SY], 1'b0};
                        r_den <= SW'({r_len, 1'b0}) << (QW - 1);
                    end else begin
                        r_ay    <= w_quo_n;
                        r_by    <= w_rem_n[RW:0];
                        r_rx    <= {2'b00, r_len};
                        r_ry    <= {2'b00, r_len};
                        r_accs  <= (RW+2)'(w_s);
                        r_trunc <= (r_prod[M_LIM] <= PW'(r_len));
                    end
                end else begin
                    r_acc <= w_rem_n;
                    r_quo <= w_quo_n;
                    r_den <= r_den >> 1;
                    r_cnt <= r_cnt + CNTW'(1);
                end
            end
            S_EMIT: begin
                if (w_adv) begin
                    r_ox     <= r_sx + w_offx;
                    r_oy     <= r_sy + w_offy;
                    r_olayer <= r_kind;
                    r_olast  <= w_last;
                    r_otrunc <= r_trunc;
                    r_rx     <= w_wrapx ? (w_sumx - w_twolen) : w_sumx;
                    r_ry     <= w_wrapy ? (w_sumy - w_twolen) : w_sumy;
                    r_qx     <= r_qx + C'(r_ax) + C'(w_wrapx);
                    r_qy     <= r_qy + C'(r_ay) + C'(w_wrapy);
                    r_i      <= r_i + IW'(1);
                    r_accs   <= w_accs_n;
                end
            end
            default: ;
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_point_x   = r_ox;
    assign o_point_y   = r_oy;
    assign o_layer     = r_olayer;
    assign o_last      = r_olast;
    assign o_truncated = r_otrunc;

endmodule

`default_nettype wire

// ===== src/mcss_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcss_regs
    import mcss_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [PAW-1:0] paddr,
    input  wire logic [PDW-1:0] pwdata,
    output logic [PDW-1:0]      prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[PAW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.radius   <= '0;
            r_cfg.spacing  <= SPACING_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CENTER_X: r_cfg.center_x <= pwdata[23:0];
                REG_CENTER_Y: r_cfg.center_y <= pwdata[23:0];
                REG_RADIUS:   r_cfg.radius   <= pwdata[22:0];
                REG_SPACING:  r_cfg.spacing  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CENTER_X: prdata = {8'd0, r_cfg.center_x};
            REG_CENTER_Y: prdata = {8'd0, r_cfg.center_y};
            REG_RADIUS:   prdata = {9'd0, r_cfg.radius};
            REG_SPACING:  prdata = {16'd0, r_cfg.spacing};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/mcss_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcss_chk
    import mcss_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_stall,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [COORD_BITS-1:0] o_point_x,
    input wire logic [COORD_BITS-1:0] o_point_y,
    input wire logic [2:0]            o_layer,
    input wire logic                  o_last,
    input wire logic                  o_truncated
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_last))
        else $error("stalled item changed");

    a_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_layer <= KIND_MAX)
        else $error("item from unknown kind");

    a_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_layer == KIND_CORNER |-> o_last && !o_truncated)
        else $error("corner item not single");

endmodule

bind map_crop_segment_sampler mcss_chk #(.COORD_BITS(COORD_BITS)) u_mcss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_point_x   (o_point_x),
    .o_point_y   (o_point_y),
    .o_layer     (o_layer),
    .o_last      (o_last),
    .o_truncated (o_truncated)
);

`default_nettype wire

// ===== sim/map_crop_segment_sampler_test.sv =====
`timescale 1ns / 1ps

module map_crop_segment_sampler_test;
    import mcss_pkg::*;

    localparam int MAXP = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 200;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [2:0]         layer;
        logic               last;
        logic               trunc;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PAW-1:0] paddr = '0;
    logic [PDW-1:0] pwdata = '0;
    logic [PDW-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_kind = '0;
    logic signed [23:0] i_start_x = '0;
    logic signed [23:0] i_start_y = '0;
    logic signed [23:0] i_end_x = '0;
    logic signed [23:0] i_end_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [23:0] o_point_x;
    logic signed [23:0] o_point_y;
    logic [2:0] o_layer;
    logic o_last;
    logic o_truncated;

    map_crop_segment_sampler dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor copy of the registers
    longint cx_q, cy_q, rad_q, spc_q;
    t_sample samples_due[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int cycles = 0;
    int hold_cycles = 0;
    int burst_left = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: long hold on request, else one of four stall patterns taken in turn
    always @(posedge i_clk) begin
        int mode;
        mode = (cycles / 150) % 4;
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 99) < 30);
                2: i_stall <= ($urandom_range(0, 99) < 75);
                default: i_stall <= ((cycles % 7) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_sample exp_s;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (samples_due.size() == 0) begin
                $error("unexpected point x=%0d y=%0d", o_point_x, o_point_y);
                errors++;
            end else begin
                exp_s = samples_due.pop_front();
                if (o_point_x !== exp_s.x) begin
                    $error("point_x expected %0d actual %0d", exp_s.x, o_point_x);
                    errors++;
                end
                if (o_point_y !== exp_s.y) begin
                    $error("point_y expected %0d actual %0d", exp_s.y, o_point_y);
                    errors++;
                end
                if (o_layer !== exp_s.layer) begin
                    $error("layer expected %0d actual %0d", exp_s.layer, o_layer);
                    errors++;
                end
                if (o_last !== exp_s.last) begin
                    $error("last expected %0d actual %0d", exp_s.last, o_last);
                    errors++;
                end
                if (o_truncated !== exp_s.trunc) begin
                    $error("truncated expected %0d actual %0d", exp_s.trunc, o_truncated);
                    errors++;
                end
            end
        end
    end

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit in_circle(longint px, longint py);
        longint ax, ay;
        ax = absl(px - cx_q);
        ay = absl(py - cy_q);
        if (ax > rad_q || ay > rad_q)
            return 1'b0;
        return (ax * ax + ay * ay) < (rad_q * rad_q);
    endfunction

    function automatic longint floor_root(longint sq);
        longint lo, hi, mid;
        lo = 0;
        hi = longint'(1) << 27;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid <= sq)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint round_ratio(longint num, longint v, longint den);
        longint p, q;
        p = num * absl(v);
        q = (2 * p + den) / (2 * den);
        return v < 0 ? -q : q;
    endfunction

    task automatic predict_samples(input logic [2:0] k, input logic signed [23:0] sx,
                                   input logic signed [23:0] sy,
                                   input logic signed [23:0] ex,
                                   input logic signed [23:0] ey);
        longint vx, vy, len, n, cnt, s;
        t_sample p;
        bit cut;
        s = (spc_q == 0) ? 1 : spc_q;
        if (k > KIND_MAX)
            return;
        if (k == KIND_CORNER) begin
            if (!in_circle(sx, sy))
                return;
            p = '{x: sx, y: sy, layer: KIND_CORNER, last: 1'b1, trunc: 1'b0};
            samples_due.insert(samples_due.size(), p);
            return;
        end
        if (!in_circle(sx, sy) && !in_circle(ex, ey))
            return;
        vx = longint'(ex) - longint'(sx);
        vy = longint'(ey) - longint'(sy);
        len = floor_root(vx * vx + vy * vy);
        n = len / s;
        cut = n > MAXP;
        cnt = cut ? MAXP : n;
        for (longint i = 0; i < cnt; i++) begin
            p.x = 24'(longint'(sx) + round_ratio(i * s, vx, len));
            p.y = 24'(longint'(sy) + round_ratio(i * s, vy, len));
            p.layer = k;
            p.last = (i + 1 == cnt);
            p.trunc = cut;
            samples_due.insert(samples_due.size(), p);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PAW'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CENTER_X: cx_q = longint'(signed'(val[23:0]));
            REG_CENTER_Y: cy_q = longint'(signed'(val[23:0]));
            REG_RADIUS:   rad_q = longint'(val[22:0]);
            default:      spc_q = longint'(val[15:0]);
        endcase
    endtask

    task automatic set_config(input longint cx, input longint cy, input longint r,
                              input longint s);
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy));
        write_reg(REG_RADIUS, 32'(r));
        write_reg(REG_SPACING, 32'(s));
    endtask

    // one item on the input channel, with bursts and gaps
    task automatic send_item(input logic [2:0] k, input longint sx, input longint sy,
                             input longint ex, input longint ey);
        i_valid <= 1'b1;
        i_kind <= k;
        i_start_x <= 24'(sx);
        i_start_y <= 24'(sy);
        i_end_x <= 24'(ex);
        i_end_y <= 24'(ey);
        do @(posedge i_clk); while (o_stall);
        predict_samples(k, 24'(sx), 24'(sy), 24'(ex), 24'(ey));
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_directed;
        set_config(0, 0, 256 * 40, 256);
        send_item(0, 100, -200, 0, 0);
        send_item(0, 256 * 40, 0, 0, 0);            // on the circle: outside
        send_item(0, 256 * 40 - 1, 0, -5, 7);
        send_item(0, 300000, 0, 0, 0);
        for (int k = 1; k <= 5; k++)
            send_item(3'(k), -1000 * k, 500, 1500 * k, -700 * k);
        send_item(6, 0, 0, 2560, 0);
        send_item(7, 0, 0, 0, 2560);
        send_item(1, 500, 500, 500, 500);           // zero length
        send_item(2, 0, 0, 255, 0);                 // shorter than spacing
        send_item(3, 0, 0, 64 * 256, 0);            // exactly max count
        send_item(4, 0, 0, 65 * 256 + 10, 0);       // capped
        send_item(5, 8388607, 8388607, -100, -100); // far start, near end
        drain();
        set_config(32'h80_0000, 32'h80_0000, 300, 0);  // spacing 0 acts as 1
        send_item(1, -8388608, -8388608, -8388608 + 120, -8388608 + 20);
        send_item(0, -8388608, -8388608, 8388607, 8388607);
        send_item(2, -8388608 + 290, -8388608, -8388608, -8388608 + 290);
        drain();
        set_config(8388607, -8388608, 8388607, 65535);
        send_item(1, 8388607, -8388608, -8388608, 8388607);
        send_item(0, 0, 0, 0, 0);
        send_item(2, 8388607, 8388607, -8388608, -8388608);
        drain();
        set_config(0, 0, 0, 100);                   // radius zero
        send_item(0, 0, 0, 0, 0);
        send_item(1, 0, 0, 5000, 0);
        drain();
    endtask

    task automatic random_item(input longint span);
        int roll;
        logic [2:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            send_item(3'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
            k = (roll < 20) ? KIND_CORNER : 3'($urandom_range(1, 5));
            send_item(k, cx_q + $urandom_range(0, 2 * span) - span,
                      cy_q + $urandom_range(0, 2 * span) - span,
                      cx_q + $urandom_range(0, 2 * span) - span,
                      cy_q + $urandom_range(0, 2 * span) - span);
        end
    endtask

    task automatic test_random;
        longint r;
        for (int ph = 0; ph < 5; ph++) begin
            r = $urandom_range(256, 30000);
            set_config(24'($urandom), 24'($urandom), r, $urandom_range(r / 12 + 1, r / 2 + 1));
            repeat (14) random_item(r + r / 4);
            drain();
        end
    endtask

    task automatic test_backpressure;
        set_config(0, 0, 4000, 100);
        hold_cycles = 3000;
        burst_left = 10;
        repeat (10) send_item(3'($urandom_range(1, 5)), -3000, 100, 3000, -200);
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cx_q = 0;
        cy_q = 0;
        rad_q = 0;
        spc_q = longint'(SPACING_RST);
        test_directed();
        test_random();
        test_backpressure();
        $display("covered %0d items and %0d points: corners, five layers, dropped kinds,",
                 items_sent, results_seen);
        $display("zero and short segments, capped counts, extreme registers, long receiver hold");
        if (errors == 0 && samples_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
